// ===== rtl/lpfd_pkg.sv =====
package lpfd_pkg;

  // Result kind codes
  localparam logic [2:0] KIND_PING        = 3'd0;
  localparam logic [2:0] KIND_SESSION_END = 3'd1;
  localparam logic [2:0] KIND_DATA        = 3'd2;
  localparam logic [2:0] KIND_SIZE_ERROR  = 3'd3;
  localparam logic [2:0] KIND_SHORT_DATA  = 3'd4;

  localparam logic [15:0] HDR_BYTES    = 16'd12;
  localparam logic [15:0] DATA_MIN     = 16'd14;
  localparam logic [31:0] END_MARK     = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_LEN_INIT = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] session_id;
    logic [31:0] packet_id;
    logic [31:0] acked_id;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        overrun;
  } result_t;

endpackage

// ===== rtl/length_prefixed_frame_deframer.sv =====
// Length-prefixed frame deframer.
// Input channel: in_valid/in_ready carry one stream byte (data_byte) per item,
// or a restart item (restart = 1) that clears reassembly and the error state.
// Output channel: out_valid/out_ready carry results: ping, session end, data
// byte, size error or short data, with the frame's three header ids.
// Config: cfg_wr_en/cfg_wr_data write max_frame_length (reset 65535); write
// it only while the block is idle.
// A result is registered and shows in the cycle after its byte is taken.
// Throughput: one byte per cycle unless stalled; each byte's state update
// is one combinational pass into the frame state and the output register.
// Reset: all frame state clears, the block waits for a length low byte and
// the output register is empty.
// Stall: while a result waits on out_ready low, in_ready drops, so no input
// is taken until that result leaves; in the cycle it is taken, a new byte
// is accepted as well.
module length_prefixed_frame_deframer
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] session_id,
  output logic [31:0] packet_id,
  output logic [31:0] acked_id,
  output logic [7:0]  payload_byte,
  output logic        last_byte,
  output logic        overrun,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] max_frame_length;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_LEN_INIT;
    end else if (cfg_wr_en) begin
      max_frame_length <= cfg_wr_data;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  lpfd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .data_byte        (data_byte),
    .restart          (restart),
    .max_frame_length (max_frame_length),
    .res_valid        (res_valid),
    .res              (res)
  );

  lpfd_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_valid (res_valid),
    .load_res   (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign kind         = out_res.kind;
  assign session_id   = out_res.session_id;
  assign packet_id    = out_res.packet_id;
  assign acked_id     = out_res.acked_id;
  assign payload_byte = out_res.payload_byte;
  assign last_byte    = out_res.last_byte;
  assign overrun      = out_res.overrun;

endmodule

// ===== rtl/lpfd_core.sv =====
module lpfd_core
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic [15:0] max_frame_length,
  output logic        res_valid,
  output result_t     res
);

  typedef enum logic [1:0] {
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY,
    PH_DROP
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  length_low_hold, length_low_hold_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] byte_offset, byte_offset_next;
  logic [31:0] header_session, header_session_next;
  logic [31:0] header_packet, header_packet_next;
  logic [31:0] header_acked, header_acked_next;
  logic [15:0] inner_length, inner_length_next;
  logic        payload_done, payload_done_next;

  logic [16:0] off_inc;
  logic        at_end;
  logic [31:0] byte_word;
  logic [15:0] len;
  logic        is_control;
  logic [16:0] inner_end;
  logic        last_in;
  logic        last;
  logic        ovr;

  always_comb begin
    phase_next           = phase;
    length_low_hold_next = length_low_hold;
    frame_length_next    = frame_length;
    byte_offset_next     = byte_offset;
    header_session_next  = header_session;
    header_packet_next   = header_packet;
    header_acked_next    = header_acked;
    inner_length_next    = inner_length;
    payload_done_next    = payload_done;
    res_valid            = 1'b0;
    res                  = '0;

    off_inc    = {1'b0, byte_offset} + 17'd1;
    at_end     = (off_inc == {1'b0, frame_length});
    byte_word  = {24'd0, data_byte} << {byte_offset[1:0], 3'b000};
    len        = {data_byte, length_low_hold};
    is_control = 1'b0;
    inner_end  = '0;
    last_in    = 1'b0;
    last       = 1'b0;
    ovr        = 1'b0;

    if (restart) begin
      phase_next           = PH_LEN_LO;
      length_low_hold_next = '0;
      frame_length_next    = '0;
      byte_offset_next     = '0;
      header_session_next  = '0;
      header_packet_next   = '0;
      header_acked_next    = '0;
      inner_length_next    = '0;
      payload_done_next    = 1'b0;
    end else begin
      case (phase)
        PH_LEN_LO: begin
          length_low_hold_next = data_byte;
          phase_next           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          frame_length_next   = len;
          byte_offset_next    = '0;
          header_session_next = '0;
          header_packet_next  = '0;
          header_acked_next   = '0;
          inner_length_next   = '0;
          payload_done_next   = 1'b0;
          if (len < HDR_BYTES || len > max_frame_length) begin
            phase_next    = PH_DROP;
            res_valid     = 1'b1;
            res.kind      = KIND_SIZE_ERROR;
          end else begin
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          // gather the three little-endian ids
          if (byte_offset < HDR_BYTES) begin
            if (byte_offset < 16'd4) begin
              header_session_next = header_session | byte_word;
            end else if (byte_offset < 16'd8) begin
              header_packet_next = header_packet | byte_word;
            end else begin
              header_acked_next = header_acked | byte_word;
            end
          end

          is_control = (header_session_next == '0) || (header_packet_next == END_MARK);

          if (is_control) begin
            if (at_end) begin
              res_valid = 1'b1;
              res.kind  = (header_session_next == '0) ? KIND_PING : KIND_SESSION_END;
            end
          end else if (frame_length < DATA_MIN) begin
            if (at_end) begin
              res_valid = 1'b1;
              res.kind  = KIND_SHORT_DATA;
            end
          end else if (byte_offset >= HDR_BYTES && !payload_done) begin
            if (byte_offset == HDR_BYTES) begin
              inner_length_next = {8'd0, data_byte};
            end else if (byte_offset == HDR_BYTES + 16'd1) begin
              inner_length_next = {data_byte, inner_length[7:0]};
            end
            inner_end = {1'b0, HDR_BYTES} + 17'd1 + {1'b0, inner_length_next};
            last_in   = (byte_offset >= HDR_BYTES + 16'd1) &&
                        ({1'b0, byte_offset} == inner_end);
            last      = last_in || at_end;
            ovr       = at_end && (inner_end > {1'b0, byte_offset});
            res_valid        = 1'b1;
            res.kind         = KIND_DATA;
            res.payload_byte = data_byte;
            res.last_byte    = last;
            res.overrun      = ovr;
            if (last) begin
              payload_done_next = 1'b1;
            end
          end

          byte_offset_next = off_inc[15:0];
          if (at_end) begin
            phase_next       = PH_LEN_LO;
            byte_offset_next = '0;
          end
        end
        PH_DROP: begin
          // drop everything until restart
        end
        default: begin
          phase_next = PH_LEN_LO;
        end
      endcase
    end

    res.session_id = header_session_next;
    res.packet_id  = header_packet_next;
    res.acked_id   = header_acked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_LO;
      length_low_hold <= '0;
      frame_length    <= '0;
      byte_offset     <= '0;
      header_session  <= '0;
      header_packet   <= '0;
      header_acked    <= '0;
      inner_length    <= '0;
      payload_done    <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      length_low_hold <= length_low_hold_next;
      frame_length    <= frame_length_next;
      byte_offset     <= byte_offset_next;
      header_session  <= header_session_next;
      header_packet   <= header_packet_next;
      header_acked    <= header_acked_next;
      inner_length    <= inner_length_next;
      payload_done    <= payload_done_next;
    end
  end

`ifndef SYNTHESIS
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (step && restart) |=> (phase == PH_LEN_LO && byte_offset == '0 && !payload_done))
    else $error("restart did not clear reassembly state");

  a_non_data_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind != KIND_DATA) |->
      (res.payload_byte == '0 && !res.last_byte && !res.overrun))
    else $error("non-data result carries payload fields");

  a_overrun_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.overrun) |-> (res.last_byte && at_end))
    else $error("overrun flagged away from frame end");

  a_size_error_ids: assert property (@(posedge clk) disable iff (rst)
    (step && res_valid && res.kind == KIND_SIZE_ERROR) |=> (phase == PH_DROP))
    else $error("size error did not enter drop phase");
`endif

endmodule

// ===== rtl/lpfd_out_reg.sv =====
module lpfd_out_reg
  import lpfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  // Hold the result until taken; a load only happens when the slot frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("pending result overwritten");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (load && load_valid) |=> out_valid)
    else $error("loaded result not shown");
`endif

endmodule

// ===== sim/deframer_checker.sv =====
module deframer_checker
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  kind,
  input  logic [31:0] session_id,
  input  logic [31:0] packet_id,
  input  logic [31:0] acked_id,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  input  logic        overrun,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          due_count,
  output int          data_seen,
  output int          cut_seen,
  output int          other_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {WAIT_LEN_LO, WAIT_LEN_HI, IN_BODY, DROPPING} deframe_phase_t;

  deframe_phase_t phase;
  logic [7:0]     len_lo;
  logic [15:0]    frame_len;
  logic [15:0]    offset;
  logic [15:0]    inner_len;
  logic [31:0]    sess;
  logic [31:0]    pkt;
  logic [31:0]    ack;
  logic           payload_done;
  logic [15:0]    max_len;

  result_t due_results[$];
  result_t want;
  int      errs;
  int      n_data;
  int      n_cut;
  int      n_other;

  task automatic clear_frame();
    offset       = '0;
    sess         = '0;
    pkt          = '0;
    ack          = '0;
    inner_len    = '0;
    payload_done = 1'b0;
  endtask

  task automatic clear_stream();
    phase     = WAIT_LEN_LO;
    len_lo    = '0;
    frame_len = '0;
    clear_frame();
  endtask

  task automatic push_result(input logic [2:0] k, input logic [7:0] pb, input logic lb,
                             input logic ov);
    result_t r;
    r.kind         = k;
    r.session_id   = sess;
    r.packet_id    = pkt;
    r.acked_id     = ack;
    r.payload_byte = pb;
    r.last_byte    = lb;
    r.overrun      = ov;
    due_results.insert(due_results.size(), r);
  endtask

  // Advance the deframer by one accepted byte and queue what it should emit.
  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    int unsigned o;
    int unsigned len;
    int unsigned sh;
    logic        at_end;
    logic        ctrl;
    logic        last_in;
    logic        fin;
    logic        ovr;
    if (rs) begin
      clear_stream();
      return;
    end
    case (phase)
      WAIT_LEN_LO: begin
        len_lo = b;
        phase  = WAIT_LEN_HI;
      end
      WAIT_LEN_HI: begin
        len       = {16'h0, b, len_lo};
        frame_len = len[15:0];
        clear_frame();
        if (len < 32'(HDR_BYTES) || len > 32'(max_len)) begin
          phase = DROPPING;
          push_result(KIND_SIZE_ERROR, 8'h00, 1'b0, 1'b0);
        end else begin
          phase = IN_BODY;
        end
      end
      IN_BODY: begin
        o      = 32'(offset);
        at_end = (o + 1 == 32'(frame_len));
        if (o < 32'(HDR_BYTES)) begin
          sh = (o % 4) * 8;
          if (o < 4)
            sess = sess | (32'(b) << sh);
          else if (o < 8)
            pkt = pkt | (32'(b) << sh);
          else
            ack = ack | (32'(b) << sh);
        end
        // session zero wins over the end mark
        ctrl = (sess == 0) || (pkt == END_MARK);
        if (ctrl) begin
          if (at_end)
            push_result((sess == 0) ? KIND_PING : KIND_SESSION_END, 8'h00, 1'b0, 1'b0);
        end else if (frame_len < DATA_MIN) begin
          if (at_end)
            push_result(KIND_SHORT_DATA, 8'h00, 1'b0, 1'b0);
        end else if (o >= 32'(HDR_BYTES) && !payload_done) begin
          if (o == 32'(HDR_BYTES))
            inner_len = {8'h00, b};
          else if (o == 32'(HDR_BYTES) + 1)
            inner_len[15:8] = b;
          last_in = (o >= 32'(HDR_BYTES) + 1) && (o == 32'(HDR_BYTES) + 1 + 32'(inner_len));
          fin     = last_in || at_end;
          ovr     = at_end && (32'(HDR_BYTES) + 1 + 32'(inner_len) > o);
          push_result(KIND_DATA, b, fin, ovr);
          if (fin)
            payload_done = 1'b1;
        end
        offset = 16'(o + 1);
        if (at_end) begin
          phase  = WAIT_LEN_LO;
          offset = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    errs++;
    if (errs <= 40)
      $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stream();
      max_len = MAX_LEN_INIT;
      due_results.delete();
      errs    = 0;
      n_data  = 0;
      n_cut   = 0;
      n_other = 0;
    end else begin
      if (cfg_wr_en)
        max_len = cfg_wr_data;
      if (in_valid && in_ready)
        deframe_byte(data_byte, restart);
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due, kind", '0, 32'(kind));
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (kind !== want.kind)
            report_mismatch("kind", 32'(want.kind), 32'(kind));
          if (session_id !== want.session_id)
            report_mismatch("session_id", want.session_id, session_id);
          if (packet_id !== want.packet_id)
            report_mismatch("packet_id", want.packet_id, packet_id);
          if (acked_id !== want.acked_id)
            report_mismatch("acked_id", want.acked_id, acked_id);
          if (payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
          if (last_byte !== want.last_byte)
            report_mismatch("last_byte", 32'(want.last_byte), 32'(last_byte));
          if (overrun !== want.overrun)
            report_mismatch("overrun", 32'(want.overrun), 32'(overrun));
          if (want.kind == KIND_DATA) begin
            n_data++;
            if (want.overrun)
              n_cut++;
          end else begin
            n_other++;
          end
        end
      end
    end
    mismatches <= errs;
    due_count  <= due_results.size();
    data_seen  <= n_data;
    cut_seen   <= n_cut;
    other_seen <= n_other;
  end

endmodule

// ===== sim/length_prefixed_frame_deframer_tb.sv =====
module length_prefixed_frame_deframer_tb
  import lpfd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [31:0] session_id;
  logic [31:0] packet_id;
  logic [31:0] acked_id;
  logic [7:0]  payload_byte;
  logic        last_byte;
  logic        overrun;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int          mismatches;
  int          due_count;
  int          data_seen;
  int          cut_seen;
  int          other_seen;

  logic        jitter;
  logic [15:0] cur_max;
  logic [15:0] max_plan [8];
  int          sent;
  int          cycles;
  int          quota;
  int          ph;

  length_prefixed_frame_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .session_id   (session_id),
    .packet_id    (packet_id),
    .acked_id     (acked_id),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .overrun      (overrun),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  deframer_checker deframe_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .session_id   (session_id),
    .packet_id    (packet_id),
    .acked_id     (acked_id),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .overrun      (overrun),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .mismatches   (mismatches),
    .due_count    (due_count),
    .data_seen    (data_seen),
    .cut_seen     (cut_seen),
    .other_seen   (other_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("length_prefixed_frame_deframer test failed");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= !rst && (!jitter || $urandom_range(99) >= 34);

  task automatic put_byte(input logic [7:0] b, input logic rs);
    while (jitter && $urandom_range(99) < 34) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    restart   <= rs;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Hold the sender until every queued result has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_max = v;
  endtask

  // Send one frame; a non-negative cut replaces that body byte by a restart.
  task automatic send_frame(input logic [15:0] len, input logic [31:0] s, input logic [31:0] p,
                            input logic [31:0] a, input logic [15:0] inner, input int cut);
    int         i;
    logic [7:0] b;
    put_byte(len[7:0], 1'b0);
    put_byte(len[15:8], 1'b0);
    for (i = 0; i < int'(len); i++) begin
      if (i == cut) begin
        put_byte(8'($urandom), 1'b1);
        return;
      end
      if (i < 4)
        b = s[8*i +: 8];
      else if (i < 8)
        b = p[8*(i-4) +: 8];
      else if (i < 12)
        b = a[8*(i-8) +: 8];
      else if (i == 12)
        b = inner[7:0];
      else if (i == 13)
        b = inner[15:8];
      else
        b = 8'($urandom);
      put_byte(b, 1'b0);
    end
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned hi;
    int unsigned span;
    int          cut;
    logic [15:0] len;
    logic [15:0] inner;
    logic [31:0] s;
    logic [31:0] p;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick < 4) begin
      // line noise, then resync
      repeat ($urandom_range(5, 1)) put_byte(8'($urandom), 1'b0);
      put_byte(8'($urandom), 1'b1);
      return;
    end
    if (cur_max < HDR_BYTES || pick < 12) begin
      if (cur_max == 16'hFFFF || $urandom_range(1) == 0)
        len = 16'($urandom_range(11));
      else
        len = 16'($urandom_range(65535, 32'(cur_max) + 1));
      put_byte(len[7:0], 1'b0);
      put_byte(len[15:8], 1'b0);
      // dropped until restart
      repeat ($urandom_range(4)) put_byte(8'($urandom), 1'b0);
      put_byte(8'($urandom), 1'b1);
      return;
    end
    hi = (cur_max < 48) ? 32'(cur_max) : 48;
    if ($urandom_range(24) == 0)
      hi = (cur_max < 400) ? 32'(cur_max) : 400;
    len = 16'($urandom_range(hi, 12));
    s = $urandom;
    p = $urandom;
    a = $urandom;
    if (s == 0)
      s = 1;
    if (p == END_MARK)
      p = 0;
    if (pick < 24) begin
      s = 0;
      if ($urandom_range(3) == 0)
        p = END_MARK;
    end else if (pick < 34) begin
      p = END_MARK;
    end else if (pick < 42) begin
      len = (cur_max > 12) ? 16'($urandom_range(13, 12)) : 16'd12;
    end
    span = (len >= DATA_MIN) ? 32'(len - DATA_MIN) : 0;
    case ($urandom_range(4))
      0:       inner = 16'(span);
      1:       inner = 16'($urandom_range(span));
      2:       inner = 16'(span + $urandom_range(20, 1));
      3:       inner = 16'hFFFF;
      default: inner = 16'h0000;
    endcase
    cut = ($urandom_range(24) == 0) ? int'($urandom_range(32'(len) - 1)) : -1;
    send_frame(len, s, p, a, inner, cut);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    restart     = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    jitter      = 1'b1;
    cur_max     = MAX_LEN_INIT;
    sent        = 0;
    max_plan    = '{16'hFFFF, 16'd48, 16'd12, 16'd0, 16'd14, 16'd13, 16'd200, 16'hFFFF};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // restart while idle, a zero length, a dropped byte, then a minimal ping
    // whose packet id is also the end mark
    put_byte(8'h5A, 1'b1);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);
    send_frame(HDR_BYTES, 32'h0, END_MARK, END_MARK, 16'h0, -1);

    for (ph = 0; ph < 8; ph++) begin
      if (ph > 0)
        write_max_len(max_plan[ph]);
      jitter <= (ph != 1);
      quota = sent + ((max_plan[ph] < HDR_BYTES) ? 60 : 250);
      while (sent < quota) random_frame();
    end

    // one longer data frame, payload cut at its very end
    jitter <= 1'b0;
    send_frame(16'd80, 32'h0102_0304, 32'h8000_0000, 32'hFFFF_FFFE, 16'hFFFF, -1);
    drain();

    $display("Stream of %0d items across 8 max-length settings from 0 to 65535.", sent);
    $display("Checked %0d payload bytes (%0d cut at frame end) and %0d other results.",
             data_seen, cut_seen, other_seen);
    if (mismatches == 0)
      $display("length_prefixed_frame_deframer test passed");
    else
      $display("length_prefixed_frame_deframer test failed");
    $finish;
  end

endmodule

// ===== length_prefixed_frame_deframer.f =====
rtl/lpfd_pkg.sv
rtl/lpfd_core.sv
rtl/lpfd_out_reg.sv
rtl/length_prefixed_frame_deframer.sv
sim/deframer_checker.sv
sim/length_prefixed_frame_deframer_tb.sv
